### rtl/dvr_pkg.sv
package dvr_pkg;

   // defaults for the top-level parameters
   localparam int MAX_NODES_DEF   = 16;
   localparam int ALIVE_TICKS_DEF = 3;

   // fixed field widths
   localparam int ID_W    = 6;
   localparam int COST_W  = 8;
   localparam int RCOST_W = 9;
   localparam int MASK_W  = 63;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 63;

   // values after reset
   localparam logic [COST_W-1:0]  VEC_RESET  = 8'hFF;
   localparam logic [RCOST_W-1:0] COST_RESET = 9'd255;

   // item operations
   typedef enum logic [1:0] {
      OP_VEC  = 2'd0,
      OP_TICK = 2'd1,
      OP_READ = 2'd2,
      OP_LOAD = 2'd3
   } op_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_CNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INFINITY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CNT_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NBR_MASK  = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]    own_id;
      logic [ID_W-1:0]    node_count;
      logic [RCOST_W-1:0] infinity_mark;
      logic [RCOST_W-1:0] count_limit;
      logic [MASK_W-1:0]  neighbor_mask;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      logic [ID_W-1:0]    node_id;
      logic [ID_W-1:0]    dest_id;
      logic [COST_W-1:0]  cost;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [RCOST_W-1:0] route_cost;
      logic [ID_W-1:0]    route_next;
      logic               changed;
   } result_type;

   typedef struct packed {
      logic [RCOST_W-1:0] cost;
      logic [ID_W-1:0]    next;
   } route_type;

   localparam int ROUTE_W = $bits(route_type);

endpackage

### rtl/dvr_ram.sv
module dvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### rtl/dvr_ctrl.sv
module dvr_ctrl #(
   parameter int MAX_NODES   = dvr_pkg::MAX_NODES_DEF,
   parameter int ALIVE_TICKS = dvr_pkg::ALIVE_TICKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dvr_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  dvr_pkg::item_type   req_item,
   output logic                done_valid,
   input  logic                done_ready,
   output dvr_pkg::result_type done_result
);

   localparam int IW = $clog2(MAX_NODES);
   localparam int VD = MAX_NODES * MAX_NODES;
   localparam int VW = $clog2(VD);
   localparam int CW = $clog2(VD + 1);
   localparam logic [1:0] ALIVE_INIT = 2'(ALIVE_TICKS);
   localparam logic [5:0] MAXN = 6'(MAX_NODES);

   typedef enum logic [17:0] {
      ST_CLEAR    = 18'h00001,
      ST_IDLE     = 18'h00002,
      ST_RD_WAIT  = 18'h00004,
      ST_LD_WAIT  = 18'h00008,
      ST_VU_START = 18'h00010,
      ST_VU_LS    = 18'h00020,
      ST_VU_I     = 18'h00040,
      ST_VU_EVAL  = 18'h00080,
      ST_TK_K     = 18'h00100,
      ST_TK_KA    = 18'h00200,
      ST_TK_J     = 18'h00400,
      ST_TK_JE    = 18'h00800,
      ST_RR_INIT  = 18'h01000,
      ST_RR_M     = 18'h02000,
      ST_RR_A     = 18'h04000,
      ST_RR_B     = 18'h08000,
      ST_RR_END   = 18'h10000,
      ST_DONE     = 18'h20000
   } state_type;

   // vector memory address of destination d, neighbor k
   function automatic logic [VW-1:0] vaddr(input logic [5:0] d, input logic [5:0] k);
      logic [12:0] p;
      p = 13'(d - 6'd1) * 13'(MAX_NODES) + 13'(k - 6'd1);
      return p[VW-1:0];
   endfunction

   // table row of an id
   function automatic logic [IW-1:0] idx(input logic [5:0] id);
      logic [5:0] v;
      v = id - 6'd1;
      return v[IW-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [CW-1:0]      clr_ff, clr_in;
   dvr_pkg::item_type  item_ff, item_in;
   logic [7:0]         ls_ff, ls_in;
   logic [6:0]         o_ff, o_in;
   logic [6:0]         m_ff, m_in;
   logic [6:0]         k_ff, k_in;
   logic [7:0]         ta_ff, ta_in;
   logic               aok_ff, aok_in;
   logic [8:0]         bc_ff, bc_in;
   logic [5:0]         bx_ff, bx_in;
   dvr_pkg::route_type orig_ff, orig_in;
   logic [5:0]         skip_ff, skip_in;
   logic               self_ff, self_in;
   logic               tick_ff, tick_in;
   logic               chg_ff, chg_in;
   logic [8:0]         rc_ff, rc_in;
   logic [5:0]         rn_ff, rn_in;

   logic               vec_we;
   logic [VW-1:0]      vec_waddr, vec_raddr;
   logic [7:0]         vec_wdata, vec_rdata;
   logic               rt_we;
   logic [IW-1:0]      rt_waddr, rt_raddr;
   dvr_pkg::route_type rt_wdata, rt_rdata;
   logic               al_we;
   logic [IW-1:0]      al_waddr, al_raddr;
   logic [1:0]         al_wdata, al_rdata;

   logic [5:0]         n;
   logic               own_ok;
   logic [5:0]         own;
   logic [7:0]         own_col;

   // memories: advertised vectors, best routes, liveness countdowns
   dvr_ram #(.WIDTH(8), .DEPTH(VD)) u_vec (
      .clock(clock), .we(vec_we), .waddr(vec_waddr), .wdata(vec_wdata),
      .raddr(vec_raddr), .rdata(vec_rdata)
   );

   dvr_ram #(.WIDTH(dvr_pkg::ROUTE_W), .DEPTH(MAX_NODES)) u_route (
      .clock(clock), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
      .raddr(rt_raddr), .rdata(rt_rdata)
   );

   dvr_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_alive (
      .clock(clock), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
      .raddr(al_raddr), .rdata(al_rdata)
   );

   // ids in use and own column validity
   assign own    = cfg.own_id;
   assign n      = (cfg.node_count > MAXN) ? MAXN : cfg.node_count;
   assign own_ok = (own != 6'd0) && (own <= MAXN);
   assign own_col = own_ok ? vec_rdata : dvr_pkg::VEC_RESET;

   // sequencer
   always_comb begin
      logic       nok;
      logic       dok;
      logic [8:0] sum;
      logic [8:0] c;
      logic [5:0] x;
      logic [8:0] t;
      logic [5:0] kb;
      dvr_pkg::route_type nr;

      state_in = state_ff;
      clr_in   = clr_ff;
      item_in  = item_ff;
      ls_in    = ls_ff;
      o_in     = o_ff;
      m_in     = m_ff;
      k_in     = k_ff;
      ta_in    = ta_ff;
      aok_in   = aok_ff;
      bc_in    = bc_ff;
      bx_in    = bx_ff;
      orig_in  = orig_ff;
      skip_in  = skip_ff;
      self_in  = self_ff;
      tick_in  = tick_ff;
      chg_in   = chg_ff;
      rc_in    = rc_ff;
      rn_in    = rn_ff;

      vec_we    = 1'b0;
      vec_waddr = '0;
      vec_wdata = '0;
      vec_raddr = '0;
      rt_we     = 1'b0;
      rt_waddr  = '0;
      rt_wdata  = '0;
      rt_raddr  = '0;
      al_we     = 1'b0;
      al_waddr  = '0;
      al_wdata  = '0;
      al_raddr  = '0;

      nok = 1'b0;
      dok = 1'b0;
      sum = '0;
      c   = '0;
      x   = '0;
      t   = '0;
      kb  = '0;
      nr  = '0;

      case (state_ff)
         // sweep every entry back to its reset value
         ST_CLEAR: begin
            vec_we    = 1'b1;
            vec_waddr = clr_ff[VW-1:0];
            vec_wdata = dvr_pkg::VEC_RESET;
            if (clr_ff < CW'(MAX_NODES)) begin
               rt_we    = 1'b1;
               rt_waddr = clr_ff[IW-1:0];
               rt_wdata = '{cost: dvr_pkg::COST_RESET, next: 6'd0};
               al_we    = 1'b1;
               al_waddr = clr_ff[IW-1:0];
               al_wdata = 2'd0;
            end
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(VD - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take an item and start its operation
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_item;
               chg_in  = 1'b0;
               rc_in   = '0;
               rn_in   = '0;
               nok = (req_item.node_id != 6'd0) && (req_item.node_id <= n);
               dok = (req_item.dest_id != 6'd0) && (req_item.dest_id <= n);
               case (req_item.op)
                  dvr_pkg::OP_VEC: begin
                     if (nok && dok) begin
                        vec_we    = 1'b1;
                        vec_waddr = vaddr(req_item.dest_id, req_item.node_id);
                        vec_wdata = req_item.cost;
                     end
                     if (nok && req_item.last) begin
                        al_we    = 1'b1;
                        al_waddr = idx(req_item.node_id);
                        al_wdata = ALIVE_INIT;
                        state_in = ST_VU_START;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  dvr_pkg::OP_TICK: begin
                     if (own_ok) begin
                        al_we    = 1'b1;
                        al_waddr = idx(own);
                        al_wdata = ALIVE_INIT;
                     end
                     k_in     = 7'd1;
                     state_in = ST_TK_K;
                  end
                  dvr_pkg::OP_READ: begin
                     rt_raddr = idx(req_item.dest_id);
                     state_in = ST_RD_WAIT;
                  end
                  dvr_pkg::OP_LOAD: begin
                     if (nok) begin
                        if (own_ok) begin
                           vec_we    = 1'b1;
                           vec_waddr = vaddr(req_item.node_id, own);
                           vec_wdata = req_item.cost;
                        end
                        rt_raddr = idx(req_item.node_id);
                        state_in = ST_LD_WAIT;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // route read answer
         ST_RD_WAIT: begin
            dok = (item_ff.dest_id != 6'd0) && (item_ff.dest_id <= n);
            if (dok) begin
               rc_in = rt_rdata.cost;
               rn_in = rt_rdata.next;
            end else begin
               rc_in = cfg.infinity_mark;
               rn_in = 6'd0;
            end
            state_in = ST_DONE;
         end

         // direct link: route to the neighbor goes straight to it
         ST_LD_WAIT: begin
            nr       = '{cost: {1'b0, item_ff.cost}, next: item_ff.node_id};
            rt_we    = 1'b1;
            rt_waddr = idx(item_ff.node_id);
            rt_wdata = nr;
            chg_in   = (nr != rt_rdata);
            state_in = ST_DONE;
         end

         // fetch the direct cost to the sender
         ST_VU_START: begin
            vec_raddr = vaddr(item_ff.node_id, own);
            state_in  = ST_VU_LS;
         end

         ST_VU_LS: begin
            ls_in    = own_col;
            o_in     = 7'd1;
            state_in = ST_VU_I;
         end

         // walk destinations
         ST_VU_I: begin
            if (o_ff > {1'b0, n}) begin
               state_in = ST_DONE;
            end else begin
               vec_raddr = vaddr(o_ff[5:0], item_ff.node_id);
               rt_raddr  = idx(o_ff[5:0]);
               state_in  = ST_VU_EVAL;
            end
         end

         ST_VU_EVAL: begin
            sum = {1'b0, vec_rdata} + {1'b0, ls_ff};
            c   = rt_rdata.cost;
            x   = rt_rdata.next;
            if (sum < c) begin
               c = sum;
               x = item_ff.node_id;
            end
            if (c > cfg.count_limit && c != cfg.infinity_mark) begin
               c = cfg.infinity_mark;
               x = 6'd0;
            end
            if (x == item_ff.node_id && c != sum) begin
               orig_in  = rt_rdata;
               skip_in  = 6'd0;
               self_in  = 1'b1;
               tick_in  = 1'b0;
               state_in = ST_RR_INIT;
            end else begin
               nr       = '{cost: c, next: x};
               rt_we    = 1'b1;
               rt_waddr = idx(o_ff[5:0]);
               rt_wdata = nr;
               chg_in   = chg_ff | (nr != rt_rdata);
               o_in     = o_ff + 7'd1;
               state_in = ST_VU_I;
            end
         end

         // reroute: cheapest live neighbor for destination o
         ST_RR_INIT: begin
            bc_in    = cfg.infinity_mark;
            bx_in    = 6'd0;
            m_in     = 7'd1;
            state_in = ST_RR_M;
         end

         ST_RR_M: begin
            if (m_ff > {1'b0, n}) begin
               state_in = ST_RR_END;
            end else begin
               vec_raddr = vaddr(o_ff[5:0], m_ff[5:0]);
               al_raddr  = idx(m_ff[5:0]);
               state_in  = ST_RR_A;
            end
         end

         ST_RR_A: begin
            ta_in     = vec_rdata;
            aok_in    = (al_rdata != 2'd0);
            vec_raddr = vaddr(m_ff[5:0], own);
            state_in  = ST_RR_B;
         end

         ST_RR_B: begin
            t = {1'b0, ta_ff} + {1'b0, own_col};
            if (t < bc_ff && m_ff[5:0] != skip_ff && m_ff[5:0] != own && aok_ff &&
                !(self_ff && m_ff == o_ff)) begin
               bc_in = t;
               bx_in = m_ff[5:0];
            end
            m_in     = m_ff + 7'd1;
            state_in = ST_RR_M;
         end

         ST_RR_END: begin
            nr       = '{cost: bc_ff, next: bx_ff};
            rt_we    = 1'b1;
            rt_waddr = idx(o_ff[5:0]);
            rt_wdata = nr;
            chg_in   = chg_ff | (nr != orig_ff);
            o_in     = o_ff + 7'd1;
            state_in = tick_ff ? ST_TK_J : ST_VU_I;
         end

         // tick: age listed neighbors in id order
         ST_TK_K: begin
            kb = k_ff[5:0] - 6'd1;
            if (k_ff > {1'b0, n}) begin
               state_in = ST_DONE;
            end else if (!cfg.neighbor_mask[kb]) begin
               k_in = k_ff + 7'd1;
            end else begin
               al_raddr = idx(k_ff[5:0]);
               state_in = ST_TK_KA;
            end
         end

         ST_TK_KA: begin
            if (al_rdata != 2'd0) begin
               al_we    = 1'b1;
               al_waddr = idx(k_ff[5:0]);
               al_wdata = al_rdata - 2'd1;
               k_in     = k_ff + 7'd1;
               state_in = ST_TK_K;
            end else if (k_ff[5:0] != own) begin
               o_in     = 7'd1;
               state_in = ST_TK_J;
            end else begin
               k_in     = k_ff + 7'd1;
               state_in = ST_TK_K;
            end
         end

         // dead neighbor: find routes through it
         ST_TK_J: begin
            if (o_ff > {1'b0, n}) begin
               k_in     = k_ff + 7'd1;
               state_in = ST_TK_K;
            end else begin
               rt_raddr = idx(o_ff[5:0]);
               state_in = ST_TK_JE;
            end
         end

         ST_TK_JE: begin
            if (rt_rdata.next == k_ff[5:0]) begin
               orig_in  = rt_rdata;
               skip_in  = k_ff[5:0];
               self_in  = 1'b0;
               tick_in  = 1'b1;
               state_in = ST_RR_INIT;
            end else begin
               o_in     = o_ff + 7'd1;
               state_in = ST_TK_J;
            end
         end

         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ls_ff   <= ls_in;
      o_ff    <= o_in;
      m_ff    <= m_in;
      k_ff    <= k_in;
      ta_ff   <= ta_in;
      aok_ff  <= aok_in;
      bc_ff   <= bc_in;
      bx_ff   <= bx_in;
      orig_ff <= orig_in;
      skip_ff <= skip_in;
      self_ff <= self_in;
      tick_ff <= tick_in;
      chg_ff  <= chg_in;
      rc_ff   <= rc_in;
      rn_ff   <= rn_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign done_valid  = (state_ff == ST_DONE);
   assign done_result = '{route_cost: rc_ff, route_next: rn_ff, changed: chg_ff};

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("item accepted but sequencer stayed idle");

   a_no_write_when_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!vec_we && !rt_we && !al_we))
      else $error("memory written while result waits");

   a_vec_addr_range: assert property (@(posedge clock) disable iff (reset)
      vec_we |-> (CW'(vec_waddr) < CW'(VD)))
      else $error("vector write outside the table");

   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RR_A) |-> (bc_ff <= cfg.infinity_mark))
      else $error("reroute candidate above infinity mark");
`endif

endmodule

### rtl/distance_vector_route_update.sv
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata, req_tlast
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata
// csr       in   csr_we                 csr_index, csr_wdata
//
// after reset a clearing pass fills the vector, route and liveness memories
// and no item is taken until it ends; a last entry walks every destination
// and may reroute some, and a tick ages the listed neighbors and reroutes
// each route through a dead one
// one item is worked at a time; a finished result waits in the output register
module distance_vector_route_update #(
   parameter int MAX_NODES   = dvr_pkg::MAX_NODES_DEF,
   parameter int ALIVE_TICKS = dvr_pkg::ALIVE_TICKS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,  // op, node_id, dest_id, cost
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,  // route_cost, route_next, changed
   input  logic                               csr_we,
   input  logic [dvr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dvr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   dvr_pkg::cfg_type    cfg_ff, cfg_in;
   dvr_pkg::item_type   item;
   dvr_pkg::result_type done_result;
   dvr_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                done_valid;
   logic                done_ready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dvr_pkg::CSR_OWN_ID:    cfg_in.own_id        = csr_wdata[5:0];
            dvr_pkg::CSR_NODE_CNT:  cfg_in.node_count    = csr_wdata[5:0];
            dvr_pkg::CSR_INFINITY:  cfg_in.infinity_mark = csr_wdata[8:0];
            dvr_pkg::CSR_CNT_LIMIT: cfg_in.count_limit   = csr_wdata[8:0];
            dvr_pkg::CSR_NBR_MASK:  cfg_in.neighbor_mask = csr_wdata[62:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{own_id: 6'd1, node_count: 6'd16, infinity_mark: 9'd255,
                     count_limit: 9'd64, neighbor_mask: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // unpack the input item
   assign item = '{op:      dvr_pkg::op_type'(req_tdata[1:0]),
                   node_id: req_tdata[7:2],
                   dest_id: req_tdata[13:8],
                   cost:    req_tdata[21:14],
                   last:    req_tlast};

   dvr_ctrl #(.MAX_NODES(MAX_NODES), .ALIVE_TICKS(ALIVE_TICKS)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_item(item),
      .done_valid(done_valid),
      .done_ready(done_ready),
      .done_result(done_result)
   );

   // output register
   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done_valid && done_ready) begin
         rsp_in       = done_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.changed, rsp_ff.route_next, rsp_ff.route_cost};

endmodule
